// File: rtl/core/tcpq_pkg.sv
package tcpq_pkg;

   localparam int TagW = 16;
   localparam int AgeW = 4;
   localparam logic [AgeW-1:0] AGE_LIMIT   = 4'd15;
   localparam logic [AgeW-1:0] MAX_AGE_RST = 4'd3;

   typedef enum logic [2:0] {
      RS_ACCEPTED = 3'd0,
      RS_BAD_CLASS = 3'd1,
      RS_FULL     = 3'd2,
      RS_SERVED   = 3'd3,
      RS_SKIPPED  = 3'd4
   } status_type;

   localparam logic       OP_ADD   = 1'b0;
   localparam logic       OP_CLOSE = 1'b1;
   localparam logic [1:0] CLS_URGENT = 2'd0;
   localparam logic [1:0] CLS_NORMAL = 2'd1;

   typedef struct packed {
      logic [AgeW-1:0] age;
      logic [TagW-1:0] tag;
   } entry_type;

   // per-cycle command broadcast along one chain
   typedef struct packed {
      logic shift;  // pop head, everything moves one cell toward the head
      logic grow;   // age every cell by one, saturating at AGE_LIMIT
      logic push;   // write new tag at the tail
   } chain_ctl_type;

   function automatic logic [AgeW-1:0] age_inc(input logic [AgeW-1:0] a);
      age_inc = (a == AGE_LIMIT) ? a : a + 1'b1;
   endfunction

endpackage

// File: rtl/core/tcpq_req_if.sv
interface tcpq_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  opcode;
   logic [1:0]  item_class;
   logic [15:0] item_tag;

   modport source (output valid, output opcode, output item_class, output item_tag,
                   input ready);
   modport sink   (input valid, input opcode, input item_class, input item_tag,
                   output ready);
endinterface

// File: rtl/core/tcpq_rsp_if.sv
interface tcpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] served_tag;
   logic [0:0]  served_class;
   logic [0:0]  last;

   modport source (output valid, output status, output served_tag, output served_class,
                   output last, input ready);
   modport sink   (input valid, input status, input served_tag, input served_class,
                   input last, output ready);
endinterface

// File: rtl/core/two_class_priority_queue_with_aging.sv
// Two-class priority queue with age expiry.
// req channel: one beat is a command. Add (opcode 0) queues item_tag in the
//   urgent (class 0) or normal (class 1) queue; close (opcode 1) ends an edition.
// rsp channel: add gives one beat (accepted, invalid class or queue full).
//   Close purges expired heads, then serves up to two tags, urgent first,
//   one beat each with last on the final one, or one "skipped" beat.
// csr_we/csr_wdata write max_age (reset 3); write only while idle.
// An add's result is loaded into the output register as the add is accepted.
//   A close runs its purge pop steps (both queues purge in parallel, up to
//   QUEUE_DEPTH steps), then its served beats. Pops are shifts of the cell
//   rows; aging of all cells happens in the cycle of the final served beat.
// One command at a time: req.ready is high only when the sequencer is idle
//   and the output register is free or being drained.
// A stalled rsp holds the output register and the sequencer waits.
// Reset (synchronous) empties both queues and restores max_age; queue
//   contents themselves are not cleared.
module two_class_priority_queue_with_aging #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [3:0]      csr_wdata,
   tcpq_req_if.sink        req,
   tcpq_rsp_if.source      rsp
);

   localparam int CW = $clog2(QUEUE_DEPTH+1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PURGE = 3'b010,
      ST_SERVE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      served_ff, served_in;    // first beat of this close already out
   logic [3:0] max_age_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   tcpq_pkg::status_type rsp_status_ff;
   logic [15:0] rsp_tag_ff;
   logic        rsp_class_ff, rsp_last_ff;

   logic       rsp_load;
   tcpq_pkg::status_type load_status;
   logic [15:0] load_tag;
   logic        load_class, load_last;

   tcpq_pkg::chain_ctl_type u_ctl, n_ctl;
   tcpq_pkg::entry_type     u_head, n_head;
   logic [CW-1:0]           u_cnt, n_cnt;

   logic out_free, accept, u_full, n_full, u_any, n_any, u_exp, n_exp, one_left;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept   = req.valid && req.ready;

   assign u_any  = (u_cnt != '0);
   assign n_any  = (n_cnt != '0);
   assign u_full = (u_cnt == CW'(QUEUE_DEPTH));
   assign n_full = (n_cnt == CW'(QUEUE_DEPTH));
   assign u_exp  = u_any && (u_head.age > max_age_ff);
   assign n_exp  = n_any && (n_head.age > max_age_ff);
   assign one_left = (u_cnt == CW'(1) && !n_any) || (n_cnt == CW'(1) && !u_any);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      served_in   = served_ff;
      u_ctl       = '0;
      n_ctl       = '0;
      rsp_load    = 1'b0;
      load_status = tcpq_pkg::RS_ACCEPTED;
      load_tag    = '0;
      load_class  = 1'b0;
      load_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.opcode == tcpq_pkg::OP_CLOSE) begin
                  state_in  = ST_PURGE;
                  served_in = 1'b0;
               end else begin
                  rsp_load = 1'b1;
                  case (req.item_class)
                     tcpq_pkg::CLS_URGENT: begin
                        if (u_full) load_status = tcpq_pkg::RS_FULL;
                        else        u_ctl.push  = 1'b1;
                     end
                     tcpq_pkg::CLS_NORMAL: begin
                        if (n_full) load_status = tcpq_pkg::RS_FULL;
                        else        n_ctl.push  = 1'b1;
                     end
                     default: load_status = tcpq_pkg::RS_BAD_CLASS;
                  endcase
               end
            end
         end
         ST_PURGE: begin
            // both heads drop in parallel until neither is expired
            u_ctl.shift = u_exp;
            n_ctl.shift = n_exp;
            if (!u_exp && !n_exp) state_in = ST_SERVE;
         end
         ST_SERVE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (!u_any && !n_any) begin
                  load_status = tcpq_pkg::RS_SKIPPED;
                  state_in    = ST_IDLE;
               end else begin
                  load_status = tcpq_pkg::RS_SERVED;
                  load_last   = served_ff || one_left;
                  if (u_any) begin
                     u_ctl.shift = 1'b1;
                     load_tag    = u_head.tag;
                  end else begin
                     n_ctl.shift = 1'b1;
                     load_tag    = n_head.tag;
                     load_class  = 1'b1;
                  end
                  // remaining entries age as the final beat goes out
                  u_ctl.grow = load_last;
                  n_ctl.grow = load_last;
                  served_in  = 1'b1;
                  if (load_last) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   tcpq_chain #(.DEPTH(QUEUE_DEPTH)) u_urgent (
      .clock    (clock),
      .reset    (reset),
      .ctl      (u_ctl),
      .push_tag (req.item_tag),
      .head     (u_head),
      .count    (u_cnt)
   );

   tcpq_chain #(.DEPTH(QUEUE_DEPTH)) u_normal (
      .clock    (clock),
      .reset    (reset),
      .ctl      (n_ctl),
      .push_tag (req.item_tag),
      .head     (n_head),
      .count    (n_cnt)
   );

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         served_ff    <= 1'b0;
         max_age_ff   <= tcpq_pkg::MAX_AGE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         served_ff    <= served_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) max_age_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= load_status;
         rsp_tag_ff    <= load_tag;
         rsp_class_ff  <= load_class;
         rsp_last_ff   <= load_last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.served_tag   = rsp_tag_ff;
   assign rsp.served_class = rsp_class_ff;
   assign rsp.last         = rsp_last_ff;

   // purge never emits a beat
   a_purge_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PURGE) |-> !rsp_load)
      else $error("beat emitted during purge");

   // a final beat from serve returns the sequencer to idle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SERVE && rsp_load && load_last) |=> (state_ff == ST_IDLE))
      else $error("close did not finish after last beat");

   // skip only when nothing was served in this close
   a_skip_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && load_status == tcpq_pkg::RS_SKIPPED) |-> !served_ff)
      else $error("skip after a served beat");

   // queue fill never exceeds the depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (u_cnt <= CW'(QUEUE_DEPTH)) && (n_cnt <= CW'(QUEUE_DEPTH)))
      else $error("queue count overflow");

endmodule

// File: rtl/core/tcpq_cell.sv
// One queue slot. Loads a new tag, takes its neighbor's entry on a pop,
// and ages in place or while moving.
module tcpq_cell (
   input  logic                   clock,
   input  tcpq_pkg::chain_ctl_type ctl,
   input  logic                   load,
   input  logic [15:0]            load_tag,
   input  tcpq_pkg::entry_type    nbr_entry,
   output tcpq_pkg::entry_type    entry
);

   tcpq_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in.tag = load_tag;
         entry_in.age = '0;
      end else if (ctl.shift) begin
         entry_in = nbr_entry;
         if (ctl.grow) entry_in.age = tcpq_pkg::age_inc(nbr_entry.age);
      end else if (ctl.grow) begin
         entry_in.age = tcpq_pkg::age_inc(entry_ff.age);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/core/tcpq_chain.sv
// One FIFO as a row of cells; cell 0 is always the head.
module tcpq_chain #(
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tcpq_pkg::chain_ctl_type ctl,
   input  logic [15:0]             push_tag,
   output tcpq_pkg::entry_type     head,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int CW = $clog2(DEPTH+1);

   tcpq_pkg::entry_type cell_q [DEPTH];
   logic [CW-1:0] count_ff, count_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      tcpq_pkg::entry_type nbr;
      if (i == DEPTH - 1) begin : g_tail
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      tcpq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load      (ctl.push && (count_ff == IDX)),
         .load_tag  (push_tag),
         .nbr_entry (nbr),
         .entry     (cell_q[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.push)       count_in = count_ff + 1'b1;
      else if (ctl.shift) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign head  = cell_q[0];
   assign count = count_ff;

endmodule

// File: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH = 16;

   // Class codes above CLS_NORMAL are rejected by the block.
   localparam logic [1:0] CLS_BAD_LO = 2'd2;
   localparam logic [1:0] CLS_BAD_HI = 2'd3;

   // One command beat as it goes onto the req channel.
   typedef struct packed {
      logic                      op;
      logic [1:0]                cls;
      logic [tcpq_pkg::TagW-1:0] tag;
   } command_type;

   // One rsp beat as the block should produce it.
   typedef struct packed {
      tcpq_pkg::status_type      status;
      logic [tcpq_pkg::TagW-1:0] tag;
      logic                      cls;
      logic                      last;
   } outcome_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_we;
   logic [3:0]      csr_wdata;

   tcpq_req_if req_bus ();
   tcpq_rsp_if rsp_bus ();

   two_class_priority_queue_with_aging #(
      .QUEUE_DEPTH (QDEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .rsp       (rsp_bus)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the two queues. Index 0 is urgent, 1 is normal.
   // ------------------------------------------------------------------
   tcpq_pkg::entry_type       slot_mem [2][QDEPTH];
   int unsigned               fill     [2];
   int unsigned               head_ix  [2];
   logic [tcpq_pkg::AgeW-1:0] age_limit;

   // beats still owed by the block, oldest first
   outcome_type     due_beats [$];

   // commands waiting for the req driver
   command_type     cmd_fifo [$];
   command_type     next_cmd;
   outcome_type     want;

   int unsigned     items_queued;
   int unsigned     req_issued;
   int unsigned     req_accepted;
   int unsigned     fault_count;

   // idle control for both sides, percent chance per free cycle
   int              send_idle_pct;
   int              rsp_idle_pct;
   int              send_gap;
   int              stall_left;

   // Works out what one accepted command does to the queues and which
   // rsp beats it owes.
   task automatic predict_command(input command_type c);
      outcome_type served [$];
      outcome_type b;
      int          q;
      int unsigned pos;
      begin
         if (c.op == tcpq_pkg::OP_ADD) begin
            b = '{status: tcpq_pkg::RS_ACCEPTED, tag: '0, cls: 1'b0,
                  last: 1'b1};
            if (c.cls != tcpq_pkg::CLS_URGENT && c.cls != tcpq_pkg::CLS_NORMAL) begin
               b.status = tcpq_pkg::RS_BAD_CLASS;
            end else begin
               q = (c.cls == tcpq_pkg::CLS_URGENT) ? 0 : 1;
               if (fill[q] >= QDEPTH) begin
                  b.status = tcpq_pkg::RS_FULL;   // dropped, queue untouched
               end else begin
                  slot_mem[q][(head_ix[q] + fill[q]) % QDEPTH] = '{age: '0, tag: c.tag};
                  fill[q]++;
               end
            end
            due_beats.push_back(b);
         end else begin
            // expired heads go first, both queues
            for (q = 0; q < 2; q++) begin
               while (fill[q] > 0 && slot_mem[q][head_ix[q]].age > age_limit) begin
                  head_ix[q] = (head_ix[q] + 1) % QDEPTH;
                  fill[q]--;
               end
            end
            // up to two served, urgent always looked at first
            while (served.size() < 2 && (fill[0] > 0 || fill[1] > 0)) begin
               q = (fill[0] > 0) ? 0 : 1;
               b = '{status: tcpq_pkg::RS_SERVED, tag: slot_mem[q][head_ix[q]].tag,
                     cls: q[0], last: 1'b0};
               head_ix[q] = (head_ix[q] + 1) % QDEPTH;
               fill[q]--;
               served.push_back(b);
            end
            if (served.size() == 0) begin
               // skipped edition: purge done, no aging
               due_beats.push_back('{status: tcpq_pkg::RS_SKIPPED, tag: '0,
                                     cls: 1'b0, last: 1'b1});
            end else begin
               foreach (served[i]) begin
                  b = served[i];
                  b.last = (i == served.size() - 1);
                  due_beats.push_back(b);
               end
               // everything left ages by one, stuck at the ceiling
               for (q = 0; q < 2; q++) begin
                  for (int k = 0; k < fill[q]; k++) begin
                     pos = (head_ix[q] + k) % QDEPTH;
                     if (slot_mem[q][pos].age != tcpq_pkg::AGE_LIMIT)
                        slot_mem[q][pos].age = slot_mem[q][pos].age + 1'b1;
                  end
               end
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_cmd(input logic op, input logic [1:0] cls,
                            input logic [tcpq_pkg::TagW-1:0] tag);
      cmd_fifo.push_back('{op: op, cls: cls, tag: tag});
      items_queued++;
   endtask

   // mostly random tags, with the two extremes mixed in
   function automatic logic [tcpq_pkg::TagW-1:0] rand_tag();
      case ($urandom_range(0, 7))
         0: rand_tag = '0;
         1: rand_tag = '1;
         default: rand_tag = tcpq_pkg::TagW'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] good_class();
      good_class = $urandom_range(0, 1) ? tcpq_pkg::CLS_NORMAL : tcpq_pkg::CLS_URGENT;
   endfunction

   function automatic logic [1:0] bad_class();
      bad_class = $urandom_range(0, 1) ? CLS_BAD_HI : CLS_BAD_LO;
   endfunction

   // Random traffic in segments: fill bursts to push a queue to full,
   // close runs to age and purge, and plain mixes. Close beats carry
   // random class/tag bits that the block must ignore.
   task automatic random_traffic(input int n);
      int          done_n;
      int          k;
      logic [1:0]  cls;
      int          r;
      begin
         done_n = 0;
         while (done_n < n) begin
            case ($urandom_range(0, 2))
               0: begin
                  cls = good_class();
                  k = $urandom_range(4, 20);
                  for (int j = 0; j < k; j++) begin
                     if ($urandom_range(0, 9) == 0)
                        queue_cmd(tcpq_pkg::OP_ADD, bad_class(), rand_tag());
                     else
                        queue_cmd(tcpq_pkg::OP_ADD, cls, rand_tag());
                  end
               end
               1: begin
                  k = $urandom_range(1, 12);
                  for (int j = 0; j < k; j++)
                     queue_cmd(tcpq_pkg::OP_CLOSE, 2'($urandom_range(0, 3)), rand_tag());
               end
               default: begin
                  k = $urandom_range(5, 30);
                  for (int j = 0; j < k; j++) begin
                     r = $urandom_range(0, 9);
                     if (r < 4)
                        queue_cmd(tcpq_pkg::OP_CLOSE, 2'($urandom_range(0, 3)),
                                  rand_tag());
                     else if (r < 9)
                        queue_cmd(tcpq_pkg::OP_ADD, good_class(), rand_tag());
                     else
                        queue_cmd(tcpq_pkg::OP_ADD, bad_class(), rand_tag());
                  end
               end
            endcase
            done_n += k;
         end
      end
   endtask

   // Let everything in flight finish before touching the register.
   task automatic wait_quiet();
      while (req_accepted != items_queued || due_beats.size() != 0)
         @(posedge clock);
      // worst case close: full purge plus two served beats
      repeat (24) @(posedge clock);
   endtask

   task automatic set_age_limit(input logic [3:0] v);
      wait_quiet();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
      age_limit = v;
   endtask

   // ------------------------------------------------------------------
   // req driver: presents one beat at a time, holds it until taken
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && req_accepted != req_issued) begin
         // beat not taken yet, hold everything
      end else if (send_gap > 0) begin
         req_bus.valid <= 1'b0;
         send_gap--;
      end else if (cmd_fifo.size() > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         send_gap = $urandom_range(1, 17) - 1;
      end else if (cmd_fifo.size() > 0) begin
         next_cmd = cmd_fifo.pop_front();
         req_bus.valid      <= 1'b1;
         req_bus.opcode     <= next_cmd.op;
         req_bus.item_class <= next_cmd.cls;
         req_bus.item_tag   <= next_cmd.tag;
         req_issued++;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // rsp back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 17) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each rsp beat against the oldest owed beat, and
   // feeds every accepted req beat to the shadow queues.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_beats.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: rsp beat with nothing owed: status %0d tag %h class %0d last %0d",
                           $realtime, rsp_bus.status, rsp_bus.served_tag,
                           rsp_bus.served_class, rsp_bus.last);
            end else begin
               want = due_beats.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.served_tag !== want.tag ||
                   rsp_bus.served_class !== want.cls || rsp_bus.last !== want.last) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"%0t: rsp mismatch (exp/got): status %0d/%0d tag %h/%h",
                               " class %0d/%0d last %0d/%0d"}, $realtime,
                              want.status, rsp_bus.status, want.tag, rsp_bus.served_tag,
                              want.cls, rsp_bus.served_class, want.last, rsp_bus.last);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_command('{op: req_bus.opcode, cls: req_bus.item_class,
                              tag: req_bus.item_tag});
            req_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = tcpq_pkg::OP_ADD;
      req_bus.item_class = tcpq_pkg::CLS_URGENT;
      req_bus.item_tag   = '0;
      rsp_bus.ready      = 1'b0;
      fill               = '{0, 0};
      head_ix            = '{0, 0};
      age_limit          = tcpq_pkg::MAX_AGE_RST;
      items_queued       = 0;
      req_issued         = 0;
      req_accepted       = 0;
      fault_count        = 0;
      send_gap           = 0;
      stall_left         = 0;
      send_idle_pct      = 10;
      rsp_idle_pct       = 10;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, register at its reset value.
      // close on empty queues: skipped
      queue_cmd(tcpq_pkg::OP_CLOSE, tcpq_pkg::CLS_URGENT, '0);
      queue_cmd(tcpq_pkg::OP_ADD, CLS_BAD_LO, '1);          // both invalid classes
      queue_cmd(tcpq_pkg::OP_ADD, CLS_BAD_HI, '0);
      queue_cmd(tcpq_pkg::OP_ADD, tcpq_pkg::CLS_URGENT, '0);
      queue_cmd(tcpq_pkg::OP_ADD, tcpq_pkg::CLS_URGENT, '1);
      queue_cmd(tcpq_pkg::OP_ADD, tcpq_pkg::CLS_NORMAL, 16'hA5A5);
      queue_cmd(tcpq_pkg::OP_CLOSE, CLS_BAD_HI, '1);        // two urgent served
      // one normal served
      queue_cmd(tcpq_pkg::OP_CLOSE, tcpq_pkg::CLS_NORMAL, 16'h5A5A);
      for (int i = 0; i < QDEPTH; i++)
         queue_cmd(tcpq_pkg::OP_ADD, tcpq_pkg::CLS_URGENT, tcpq_pkg::TagW'(16'h1000 + i));
      // queue full, dropped
      queue_cmd(tcpq_pkg::OP_ADD, tcpq_pkg::CLS_URGENT, 16'hDEAD);

      // Limit 0: anything that has aged once is purged at the next close.
      set_age_limit(4'd0);
      send_idle_pct = 15;
      rsp_idle_pct  = 15;
      random_traffic(200);

      // Top of the register: nothing is ever purged, ages pin at 15.
      set_age_limit(4'd15);
      send_idle_pct = 10;
      rsp_idle_pct  = 30;
      random_traffic(250);

      // One below the ceiling, no idling on either side.
      set_age_limit(4'd14);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      random_traffic(200);

      set_age_limit(4'($urandom_range(1, 13)));
      send_idle_pct = 30;
      rsp_idle_pct  = 10;
      random_traffic(200);

      set_age_limit(4'd7);
      send_idle_pct = 20;
      rsp_idle_pct  = 20;
      random_traffic(200);

      // Closing stretch at full rate.
      set_age_limit(4'($urandom_range(0, 15)));
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      random_traffic(300);

      wait_quiet();

      if (fault_count == 0 && due_beats.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hang guard, several times the slowest legal run.
   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
